@@ hdl/xss_pkg.sv @@
package xss_pkg;

	localparam int SECTION_BYTES = 65536;
	localparam int KEY_MAX_BYTES = 256;
	localparam int KEY_AW        = $clog2(KEY_MAX_BYTES);
	localparam int KEY_LW        = $clog2(KEY_MAX_BYTES + 1);
	localparam int OFFSET_W      = $clog2(SECTION_BYTES + 1);

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_APPEND  = 2'd1;
	localparam logic [1:0] OP_SECTION = 2'd2;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_ERROR     = 2'd2;
	localparam logic [1:0] ST_TOO_LARGE = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [13:0] entry_count;
		logic [16:0] names_total;
		logic        well_formed;
	} result_t;

endpackage

@@ hdl/xattr_section_scanner_top.sv @@
// Extended-attribute section scanner.
// Item channel (item_valid / item_stall): one beat per key byte or section byte.
//   operation 0 clears the search key, 1 appends data_byte to it (up to 256 bytes),
//   2 feeds one section byte; last marks the final section byte. Key beats taken
//   in the middle of a section are dropped.
// Result channel (result_valid / result_stall): one beat per section, carrying
//   status, value offset and length, entry count, name list total and well_formed.
// Configuration: cfg_we writes cfg_data into value_capacity (reset 65535); write
//   it only while no section is in flight.
// Throughput: one beat per cycle unless item_stall is high. Each beat is registered,
//   then parsed in a single pass against a key byte prefetched from the key memory.
// The final section beat is registered and parsed; result_valid is then registered.
// Stall: a waiting result stays in the output register; the input register keeps
//   taking beats until a final beat finds the output still occupied, then
//   item_stall rises until result_stall drops.
// Reset: clears the key length, the parse state and both registers' valid flags;
//   value_capacity returns to 65535. Key memory contents are not cleared.
module xattr_section_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [15:0] value_offset,
	output logic [15:0] value_length,
	output logic [13:0] entry_count,
	output logic [16:0] names_total,
	output logic        well_formed
);

	logic             valid_s1;
	xss_pkg::beat_t   beat_s1;
	logic [15:0]      capacity_q;
	logic             out_free;
	logic             take;
	logic             accept;
	logic             emit;
	xss_pkg::result_t res;
	xss_pkg::result_t result_q;

	assign out_free   = !result_valid || !result_stall;
	assign take       = valid_s1 &&
		(!(beat_s1.operation == xss_pkg::OP_SECTION && beat_s1.last) || out_free);
	assign item_stall = valid_s1 && !take;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			beat_s1 <= '{operation: operation, data_byte: data_byte, last: last};
	end

	xss_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.value_capacity (capacity_q),
		.take           (take),
		.beat           (beat_s1),
		.emit           (emit),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= res;
	end

	assign status       = result_q.status;
	assign value_offset = result_q.value_offset;
	assign value_length = result_q.value_length;
	assign entry_count  = result_q.entry_count;
	assign names_total  = result_q.names_total;
	assign well_formed  = result_q.well_formed;

endmodule

@@ hdl/xss_parser.sv @@
module xss_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      value_capacity,
	input  logic             take,
	input  xss_pkg::beat_t   beat,
	output logic             emit,
	output xss_pkg::result_t res
);

	localparam logic [2:0] PH_COUNT = 3'd0;
	localparam logic [2:0] PH_NLEN  = 3'd1;
	localparam logic [2:0] PH_NAME  = 3'd2;
	localparam logic [2:0] PH_VLEN  = 3'd3;
	localparam logic [2:0] PH_VALUE = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;
	localparam logic [2:0] PH_EXTRA = 3'd6;

	localparam logic [1:0] LK_NONE  = 2'd0;
	localparam logic [1:0] LK_FOUND = 2'd1;
	localparam logic [1:0] LK_BIG   = 2'd3;

	logic [7:0] key_mem [xss_pkg::KEY_MAX_BYTES];
	logic [7:0] key_rd_q;
	logic       key_wr;

	logic [xss_pkg::KEY_LW-1:0]   key_len_q, key_len_d;
	logic [xss_pkg::KEY_AW-1:0]   name_idx_q, name_idx_d;
	logic [2:0]                   phase_q, phase_d;
	logic [31:0]                  acc_q, acc_d, acc_new;
	logic [1:0]                   fidx_q, fidx_d;
	logic [31:0]                  ent_rem_q, ent_rem_d;
	logic [31:0]                  byte_rem_q, byte_rem_d;
	logic [xss_pkg::OFFSET_W-1:0] offset_q, offset_d, off_inc;
	logic                         match_q, match_d;
	logic [1:0]                   lk_q, lk_d;
	logic [15:0]                  found_off_q, found_off_d;
	logic [31:0]                  found_len_q, found_len_d;
	logic [13:0]                  parsed_q, parsed_d;
	logic [16:0]                  names_q, names_d;
	logic [15:0]                  pend_q, pend_d;
	logic                         ovf_q, ovf_d;
	logic                         finish;
	logic [17:0]                  names_sum;
	logic                         hit;

	always_comb begin
		key_len_d   = key_len_q;
		name_idx_d  = name_idx_q;
		phase_d     = phase_q;
		acc_d       = acc_q;
		fidx_d      = fidx_q;
		ent_rem_d   = ent_rem_q;
		byte_rem_d  = byte_rem_q;
		offset_d    = offset_q;
		match_d     = match_q;
		lk_d        = lk_q;
		found_off_d = found_off_q;
		found_len_d = found_len_q;
		parsed_d    = parsed_q;
		names_d     = names_q;
		pend_d      = pend_q;
		ovf_d       = ovf_q;
		key_wr      = 1'b0;
		emit        = 1'b0;
		finish      = 1'b0;
		hit         = 1'b0;
		res         = '0;
		acc_new     = acc_q | ({24'd0, beat.data_byte} << {fidx_q, 3'b000});
		off_inc     = offset_q + 1'b1;
		names_sum   = {1'b0, names_q} + {2'b00, pend_q} + 18'd1;

		if (take) begin
			case (beat.operation)
				xss_pkg::OP_CLEAR: begin
					if (offset_q == '0)
						key_len_d = '0;
				end
				xss_pkg::OP_APPEND: begin
					if (offset_q == '0 && key_len_q < xss_pkg::KEY_LW'(xss_pkg::KEY_MAX_BYTES)) begin
						key_wr    = 1'b1;
						key_len_d = key_len_q + 1'b1;
					end
				end
				xss_pkg::OP_SECTION: begin
					if (offset_q == xss_pkg::OFFSET_W'(xss_pkg::SECTION_BYTES)) begin
						ovf_d = 1'b1;
					end else begin
						offset_d = off_inc;
						unique case (phase_q)
							PH_COUNT: begin
								if (fidx_q == 2'd3) begin
									ent_rem_d = acc_new;
									acc_d     = '0;
									fidx_d    = '0;
									phase_d   = (acc_new != '0) ? PH_NLEN : PH_DONE;
								end else begin
									acc_d  = acc_new;
									fidx_d = fidx_q + 1'b1;
								end
							end
							PH_NLEN: begin
								if (fidx_q == 2'd1) begin
									acc_d      = '0;
									fidx_d     = '0;
									pend_d     = acc_new[15:0];
									name_idx_d = '0;
									match_d    = (lk_q == LK_NONE) &&
										(16'(key_len_q) == acc_new[15:0]);
									byte_rem_d = {16'd0, acc_new[15:0]};
									phase_d    = (acc_new[15:0] == '0) ? PH_VLEN : PH_NAME;
								end else begin
									acc_d  = acc_new;
									fidx_d = fidx_q + 1'b1;
								end
							end
							PH_NAME: begin
								if (match_q && key_rd_q != beat.data_byte)
									match_d = 1'b0;
								name_idx_d = name_idx_q + 1'b1;
								byte_rem_d = byte_rem_q - 1'b1;
								if (byte_rem_q == 32'd1)
									phase_d = PH_VLEN;
							end
							PH_VLEN: begin
								if (fidx_q == 2'd3) begin
									acc_d  = '0;
									fidx_d = '0;
									if (match_q) begin
										found_off_d = off_inc[16] ? 16'hFFFF : off_inc[15:0];
										found_len_d = acc_new;
									end
									if (acc_new == '0) begin
										finish = 1'b1;
									end else begin
										byte_rem_d = acc_new;
										phase_d    = PH_VALUE;
									end
								end else begin
									acc_d  = acc_new;
									fidx_d = fidx_q + 1'b1;
								end
							end
							PH_VALUE: begin
								byte_rem_d = byte_rem_q - 1'b1;
								if (byte_rem_q == 32'd1)
									finish = 1'b1;
							end
							default: phase_d = PH_EXTRA;
						endcase
						if (finish) begin
							if (match_d)
								lk_d = ({16'd0, value_capacity} < found_len_d) ? LK_BIG : LK_FOUND;
							match_d   = 1'b0;
							parsed_d  = (parsed_q == 14'h3FFF) ? parsed_q : parsed_q + 1'b1;
							names_d   = names_sum[17] ? 17'h1FFFF : names_sum[16:0];
							ent_rem_d = ent_rem_q - 1'b1;
							phase_d   = (ent_rem_q != 32'd1) ? PH_NLEN : PH_DONE;
						end
					end

					if (beat.last) begin
						emit = 1'b1;
						if (lk_d == LK_FOUND)
							res.status = xss_pkg::ST_FOUND;
						else if (lk_d == LK_BIG)
							res.status = xss_pkg::ST_TOO_LARGE;
						else if (!ovf_d && (phase_d == PH_DONE || phase_d == PH_EXTRA))
							res.status = xss_pkg::ST_NOT_FOUND;
						else
							res.status = xss_pkg::ST_ERROR;
						hit = (lk_d == LK_FOUND) || (lk_d == LK_BIG);
						res.value_offset = hit ? found_off_d : '0;
						res.value_length = hit ?
							((found_len_d[31:16] != '0) ? 16'hFFFF : found_len_d[15:0]) : '0;
						res.entry_count  = parsed_d;
						res.names_total  = names_d;
						res.well_formed  = (phase_d == PH_DONE) && !ovf_d;

						name_idx_d  = '0;
						phase_d     = PH_COUNT;
						acc_d       = '0;
						fidx_d      = '0;
						ent_rem_d   = '0;
						byte_rem_d  = '0;
						offset_d    = '0;
						match_d     = 1'b0;
						lk_d        = LK_NONE;
						found_off_d = '0;
						found_len_d = '0;
						parsed_d    = '0;
						names_d     = '0;
						pend_d      = '0;
						ovf_d       = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr)
			key_mem[key_len_q[xss_pkg::KEY_AW-1:0]] <= beat.data_byte;
		key_rd_q <= key_mem[name_idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q   <= '0;
			name_idx_q  <= '0;
			phase_q     <= PH_COUNT;
			acc_q       <= '0;
			fidx_q      <= '0;
			ent_rem_q   <= '0;
			byte_rem_q  <= '0;
			offset_q    <= '0;
			match_q     <= 1'b0;
			lk_q        <= LK_NONE;
			found_off_q <= '0;
			found_len_q <= '0;
			parsed_q    <= '0;
			names_q     <= '0;
			pend_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			key_len_q   <= key_len_d;
			name_idx_q  <= name_idx_d;
			phase_q     <= phase_d;
			acc_q       <= acc_d;
			fidx_q      <= fidx_d;
			ent_rem_q   <= ent_rem_d;
			byte_rem_q  <= byte_rem_d;
			offset_q    <= offset_d;
			match_q     <= match_d;
			lk_q        <= lk_d;
			found_off_q <= found_off_d;
			found_len_q <= found_len_d;
			parsed_q    <= parsed_d;
			names_q     <= names_d;
			pend_q      <= pend_d;
			ovf_q       <= ovf_d;
		end
	end

endmodule

@@ hdl/xss_checker.sv @@
module xss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [15:0] cfg_data,
	input logic        item_valid,
	input logic        item_stall,
	input logic [1:0]  operation,
	input logic [7:0]  data_byte,
	input logic        last,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [15:0] value_offset,
	input logic [15:0] value_length,
	input logic [13:0] entry_count,
	input logic [16:0] names_total,
	input logic        well_formed
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
			$stable(value_offset) && $stable(value_length) && $stable(entry_count) &&
			$stable(names_total) && $stable(well_formed))
		else $error("stalled result beat changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == xss_pkg::ST_NOT_FOUND || status == xss_pkg::ST_ERROR)
			|-> value_offset == '0 && value_length == '0)
		else $error("miss carries value fields");

	a_hit_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == xss_pkg::ST_FOUND || status == xss_pkg::ST_TOO_LARGE)
			|-> value_offset >= 16'd10)
		else $error("value offset before first possible value");

	a_big_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == xss_pkg::ST_TOO_LARGE |-> value_length != '0)
		else $error("too large with empty value");

	a_wf_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && well_formed |-> status != xss_pkg::ST_ERROR)
		else $error("well formed section reported as structural error");

endmodule

bind xattr_section_scanner_top xss_checker u_xss_checker (.*);
